### hdl/euler_to_axis_angle_assert.svh
// assertion macros for the euler to axis-angle block
// used by the port checker, no other dependencies
`ifndef EULER_TO_AXIS_ANGLE_ASSERT_SVH
`define EULER_TO_AXIS_ANGLE_ASSERT_SVH

// same-cycle implication
`define ETA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ETA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/eta_pkg.sv
// shared constants, types and helper functions of the euler to axis-angle block
// no dependencies
package eta_pkg;

	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CW = 34;        // cordic and quaternion datapath, q2.30 with headroom
	localparam int MW = 33;        // multiplier operand width
	localparam int QBITS = 15;     // quotient bits of one axis component
	localparam int SQ_STEPS = 32;  // digit steps of a 64-bit integer square root

	typedef logic signed [CW-1:0] cw_t;
	typedef logic signed [MW-1:0] mw_t;

	localparam cw_t Q30_ONE = 34'sd1073741824;
	localparam cw_t Q30_HALF_PI = 34'sd1686629713;
	localparam cw_t Q30_PI = 34'sd3373259426;
	localparam cw_t GAIN_Q30 = 34'sd652032874;
	localparam logic [63:0] SMALL_NORM = 64'd1152921504606847;
	localparam logic signed [15:0] AXIS_ONE = 16'sd16384;

	typedef struct packed {
		logic        wneg;
		logic [30:0] wabs;
		cw_t         x;
		cw_t         y;
		cw_t         z;
		logic        small_n;
	} sq_sb_t;

	typedef struct packed {
		logic        wneg;
		cw_t         x;
		cw_t         y;
		cw_t         z;
		logic [31:0] len;
		logic        small_n;
	} vec_sb_t;

	typedef struct packed {
		logic [15:0] angle;
		logic [31:0] len;
		logic [2:0]  neg;
		logic        small_n;
	} div_sb_t;

	typedef struct packed {
		logic signed [15:0] axis_first;
		logic signed [15:0] axis_second;
		logic signed [15:0] axis_third;
		logic [15:0]        rotation_angle;
	} res_t;

	// atan(2^-i) in q2.30, truncated
	function automatic cw_t atan_q30(input int unsigned i);
		case (i)
			0:  return cw_t'(32'h3243F6A8);
			1:  return cw_t'(32'h1DAC6705);
			2:  return cw_t'(32'h0FADBAFC);
			3:  return cw_t'(32'h07F56EA6);
			4:  return cw_t'(32'h03FEAB76);
			5:  return cw_t'(32'h01FFD55B);
			6:  return cw_t'(32'h00FFFAAA);
			7:  return cw_t'(32'h007FFF55);
			8:  return cw_t'(32'h003FFFEA);
			9:  return cw_t'(32'h001FFFFD);
			10: return cw_t'(32'h000FFFFF);
			11: return cw_t'(32'h0007FFFF);
			12: return cw_t'(32'h0003FFFF);
			13: return cw_t'(32'h0001FFFF);
			14: return cw_t'(32'h0000FFFF);
			15: return cw_t'(32'h00007FFF);
			16: return cw_t'(32'h00003FFF);
			17: return cw_t'(32'h00001FFF);
			18: return cw_t'(32'h00000FFF);
			19: return cw_t'(32'h000007FF);
			20: return cw_t'(32'h000003FF);
			21: return cw_t'(32'h000001FF);
			22: return cw_t'(32'h000000FF);
			23: return cw_t'(32'h0000007F);
			24: return cw_t'(32'h0000003F);
			25: return cw_t'(32'h0000001F);
			26: return cw_t'(32'h0000000F);
			27: return cw_t'(32'h00000007);
			28: return cw_t'(32'h00000003);
			29: return cw_t'(32'h00000001);
			default: return '0;
		endcase
	endfunction

	// q2.30 product, rounded half away from zero
	function automatic mw_t mul30(input mw_t a, input mw_t b);
		logic signed [2*MW-1:0] p;
		logic [2*MW-1:0] m;
		logic [2*MW-1:0] r;
		p = a * b;
		m = p[2*MW-1] ? $unsigned(-p) : $unsigned(p);
		r = (m + ((2*MW)'(1) << 29)) >> 30;
		return p[2*MW-1] ? -mw_t'(r[MW-1:0]) : mw_t'(r[MW-1:0]);
	endfunction

endpackage

### hdl/eta_in_if.sv
// input channel of the euler to axis-angle block: three angles
// depends on eta_pkg
interface eta_in_if import eta_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] angle_x;
	logic signed [ANGLE_WIDTH-1:0] angle_y;
	logic signed [ANGLE_WIDTH-1:0] angle_z;

	modport source (output valid, output angle_x, output angle_y, output angle_z, input ready);
	modport sink (input valid, input angle_x, input angle_y, input angle_z, output ready);
endinterface

### hdl/eta_out_if.sv
// output channel of the euler to axis-angle block: axis and rotation angle
// no dependencies
interface eta_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] axis_first;
	logic signed [15:0] axis_second;
	logic signed [15:0] axis_third;
	logic [15:0]        rotation_angle;

	modport source (output valid, output axis_first, output axis_second, output axis_third,
		output rotation_angle, input ready);
	modport sink (input valid, input axis_first, input axis_second, input axis_third,
		input rotation_angle, output ready);
endinterface

### hdl/eta_rot_cell.sv
// one rotation-mode cordic step for one lane
// depends on eta_pkg
module eta_rot_cell import eta_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  cw_t  x,
	input  cw_t  y,
	input  cw_t  h,
	output cw_t  x_s1,
	output cw_t  y_s1,
	output cw_t  h_s1
);
	localparam cw_t ATAN = atan_q30(STEP);

	always_ff @(posedge clk) begin
		if (en) begin
			if (!h[CW-1]) begin
				x_s1 <= x - (y >>> STEP);
				y_s1 <= y + (x >>> STEP);
				h_s1 <= h - ATAN;
			end else begin
				x_s1 <= x + (y >>> STEP);
				y_s1 <= y - (x >>> STEP);
				h_s1 <= h + ATAN;
			end
		end
	end
endmodule

### hdl/eta_vec_cell.sv
// one vectoring-mode cordic step, accumulates the angle
// depends on eta_pkg
module eta_vec_cell import eta_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic clk,
	input  logic en,
	input  cw_t  x,
	input  cw_t  y,
	input  cw_t  z,
	output cw_t  x_s1,
	output cw_t  y_s1,
	output cw_t  z_s1
);
	localparam cw_t ATAN = atan_q30(STEP);

	always_ff @(posedge clk) begin
		if (en) begin
			if (y > cw_t'(0)) begin
				x_s1 <= x + (y >>> STEP);
				y_s1 <= y - (x >>> STEP);
				z_s1 <= z + ATAN;
			end else begin
				x_s1 <= x - (y >>> STEP);
				y_s1 <= y + (x >>> STEP);
				z_s1 <= z - ATAN;
			end
		end
	end
endmodule

### hdl/eta_sqrt_cell.sv
// one digit step of a 64-bit integer square root
// depends on eta_pkg
module eta_sqrt_cell import eta_pkg::*; #(
	parameter int STEP = 0
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] v,
	input  logic [63:0] r,
	output logic [63:0] v_s1,
	output logic [63:0] r_s1
);
	localparam logic [63:0] BIT = 64'd1 << (2 * (SQ_STEPS - 1 - STEP));

	logic [64:0] trial;

	assign trial = {1'b0, r} + {1'b0, BIT};

	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, v} >= trial) begin
				v_s1 <= v - trial[63:0];
				r_s1 <= (r >> 1) + BIT;
			end else begin
				v_s1 <= v;
				r_s1 <= r >> 1;
			end
		end
	end
endmodule

### hdl/eta_div_cell.sv
// one restoring division step: brings in one numerator bit, yields one quotient bit
// depends on eta_pkg
module eta_div_cell import eta_pkg::*; (
	input  logic             clk,
	input  logic             en,
	input  logic [32:0]      rem,
	input  logic [QBITS-1:0] q,
	input  logic [QBITS-1:0] nlow,
	input  logic [31:0]      len,
	output logic [32:0]      rem_s1,
	output logic [QBITS-1:0] q_s1,
	output logic [QBITS-1:0] nlow_s1
);
	logic [32:0] shifted;

	// remainder stays below len, so its top bit is free
	assign shifted = {rem[31:0], nlow[QBITS-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			nlow_s1 <= nlow << 1;
			if (shifted >= {1'b0, len}) begin
				rem_s1 <= shifted - {1'b0, len};
				q_s1   <= {q[QBITS-2:0], 1'b1};
			end else begin
				rem_s1 <= shifted;
				q_s1   <= {q[QBITS-2:0], 1'b0};
			end
		end
	end
endmodule

### hdl/euler_to_axis_angle.sv
// channel   dir  payload
// angles    in   angle_x, angle_y, angle_z: signed q3.13 radians (ANGLE_WIDTH bits)
// rotation  out  axis_first/second/third: signed q1.14, rotation_angle: unsigned q3.13
//
// one transfer in per cycle while angles.ready is high, one result per transfer
// the pipeline runs through the sine/cosine cordic, five product stages,
// 32 square-root steps per lane, the vectoring cordic and 15 divider steps per lane
// arst_n clears the valid chain and the output stage; data registers are not reset
// a stalled output holds its result and a skid register takes one more, then angles.ready drops
module euler_to_axis_angle import eta_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	eta_in_if.sink     angles,
	eta_out_if.source  rotation
);
	localparam int NS = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
	localparam int SQ0 = NS + 5;
	localparam int VC0 = SQ0 + SQ_STEPS;
	localparam int PREP = VC0 + NS;
	localparam int DV0 = PREP + 1;
	localparam int LAT = DV0 + QBITS;

	logic en;
	logic push;
	logic vld_q [LAT];
	logic out_vld_q;
	logic skid_vld_q;
	res_t res_q;
	res_t skid_q;
	res_t tail;

	assign en = !skid_vld_q;
	assign angles.ready = en;
	assign push = en && vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) vld_q[k] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= angles.valid;
			for (int k = 1; k < LAT; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// half angles and quadrant fold
	cw_t h_in [3];
	cw_t h_fold [3];
	logic [2:0] flip_in;

	always_comb begin
		h_in[0] = cw_t'(angles.angle_x) <<< (32 - ANGLE_WIDTH);
		h_in[1] = -(cw_t'(angles.angle_z) <<< (32 - ANGLE_WIDTH));
		h_in[2] = cw_t'(angles.angle_y) <<< (32 - ANGLE_WIDTH);
		for (int l = 0; l < 3; l++) begin
			flip_in[l] = 1'b1;
			if (h_in[l] > Q30_HALF_PI) begin
				h_fold[l] = h_in[l] - Q30_PI;
			end else if (h_in[l] < -Q30_HALF_PI) begin
				h_fold[l] = h_in[l] + Q30_PI;
			end else begin
				h_fold[l] = h_in[l];
				flip_in[l] = 1'b0;
			end
		end
	end

	// sine/cosine cordic chain, lanes a1, -a3, a2
	cw_t rx [NS+1][3];
	cw_t ry [NS+1][3];
	cw_t rh [NS+1][3];
	logic [2:0] rot_flip_q [NS];

	genvar k, l;
	generate
		for (l = 0; l < 3; l++) begin : g_rot_in
			assign rx[0][l] = GAIN_Q30;
			assign ry[0][l] = '0;
			assign rh[0][l] = h_fold[l];
		end
		for (k = 0; k < NS; k++) begin : g_rot
			for (l = 0; l < 3; l++) begin : g_lane
				eta_rot_cell #(.STEP(k)) u_cell (
					.clk(clk), .en(en),
					.x(rx[k][l]), .y(ry[k][l]), .h(rh[k][l]),
					.x_s1(rx[k+1][l]), .y_s1(ry[k+1][l]), .h_s1(rh[k+1][l])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			rot_flip_q[0] <= flip_in;
			for (int i = 1; i < NS; i++) rot_flip_q[i] <= rot_flip_q[i-1];
		end
	end

	// quaternion products
	mw_t cc [3];
	mw_t ss [3];
	mw_t c1c2_s1, s1s2_s1, s1c2_s1, c1s2_s1, c3_s1, s3_s1;
	mw_t w1_s2, w2_s2, x1_s2, x2_s2, y1_s2, y2_s2, z1_s2, z2_s2;
	cw_t w_s3, x_s3, y_s3, z_s3;
	cw_t w_sum;
	logic        wneg_s4;
	logic [30:0] wabs_s4;
	logic [63:0] wsq_s4, xsq_s4, ysq_s4, zsq_s4;
	cw_t x_s4, y_s4, z_s4;
	logic [61:0] wsq;
	logic signed [2*CW-1:0] xsq, ysq, zsq;
	cw_t wabs_full;
	logic [63:0] n_sum;
	logic [63:0] sarg_s5, n_s5;
	sq_sb_t sb_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cc[i] = rot_flip_q[NS-1][i] ? mw_t'(-rx[NS][i]) : mw_t'(rx[NS][i]);
			ss[i] = rot_flip_q[NS-1][i] ? mw_t'(-ry[NS][i]) : mw_t'(ry[NS][i]);
		end
		w_sum = cw_t'(w1_s2) - cw_t'(w2_s2);
		wabs_full = w_s3[CW-1] ? -w_s3 : w_s3;
		// squares are taken from the saturated stage so they line up with the sideband
		wsq = wabs_full[30:0] * wabs_full[30:0];
		xsq = x_s3 * x_s3;
		ysq = y_s3 * y_s3;
		zsq = z_s3 * z_s3;
		n_sum = xsq_s4 + ysq_s4 + zsq_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c1c2_s1 <= mul30(cc[0], cc[1]);
			s1s2_s1 <= mul30(ss[0], ss[1]);
			s1c2_s1 <= mul30(ss[0], cc[1]);
			c1s2_s1 <= mul30(cc[0], ss[1]);
			c3_s1   <= cc[2];
			s3_s1   <= ss[2];

			w1_s2 <= mul30(c1c2_s1, c3_s1);
			w2_s2 <= mul30(s1s2_s1, s3_s1);
			x1_s2 <= mul30(c1c2_s1, s3_s1);
			x2_s2 <= mul30(s1s2_s1, c3_s1);
			y1_s2 <= mul30(s1c2_s1, c3_s1);
			y2_s2 <= mul30(c1s2_s1, s3_s1);
			z1_s2 <= mul30(c1s2_s1, c3_s1);
			z2_s2 <= mul30(s1c2_s1, s3_s1);

			// w saturates to the unit range
			if (w_sum > Q30_ONE) w_s3 <= Q30_ONE;
			else if (w_sum < -Q30_ONE) w_s3 <= -Q30_ONE;
			else w_s3 <= w_sum;
			x_s3 <= cw_t'(x1_s2) + cw_t'(x2_s2);
			y_s3 <= cw_t'(y1_s2) - cw_t'(y2_s2);
			z_s3 <= cw_t'(z1_s2) - cw_t'(z2_s2);

			wneg_s4 <= w_s3[CW-1];
			wabs_s4 <= wabs_full[30:0];
			x_s4    <= x_s3;
			y_s4    <= y_s3;
			z_s4    <= z_s3;

			wsq_s4 <= {2'b0, wsq};
			xsq_s4 <= xsq[63:0];
			ysq_s4 <= ysq[63:0];
			zsq_s4 <= zsq[63:0];

			sarg_s5       <= (64'd1 << 60) - wsq_s4;
			n_s5          <= n_sum;
			sb_s5.wneg    <= wneg_s4;
			sb_s5.wabs    <= wabs_s4;
			sb_s5.x       <= x_s4;
			sb_s5.y       <= y_s4;
			sb_s5.z       <= z_s4;
			sb_s5.small_n <= (n_sum < SMALL_NORM);
		end
	end

	// square root chain: lane 0 gives sin of the half angle, lane 1 the axis length
	logic [63:0] sqv [SQ_STEPS+1][2];
	logic [63:0] sqr [SQ_STEPS+1][2];
	sq_sb_t sq_sb_q [SQ_STEPS];

	assign sqv[0][0] = sarg_s5;
	assign sqv[0][1] = n_s5;
	assign sqr[0][0] = '0;
	assign sqr[0][1] = '0;

	generate
		for (k = 0; k < SQ_STEPS; k++) begin : g_sq
			for (l = 0; l < 2; l++) begin : g_lane
				eta_sqrt_cell #(.STEP(k)) u_cell (
					.clk(clk), .en(en),
					.v(sqv[k][l]), .r(sqr[k][l]),
					.v_s1(sqv[k+1][l]), .r_s1(sqr[k+1][l])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			sq_sb_q[0] <= sb_s5;
			for (int i = 1; i < SQ_STEPS; i++) sq_sb_q[i] <= sq_sb_q[i-1];
		end
	end

	// vectoring cordic: atan2(sin, |w|)
	cw_t vx [NS+1];
	cw_t vy [NS+1];
	cw_t vz [NS+1];
	vec_sb_t vec_in;
	vec_sb_t vec_sb_q [NS];

	assign vx[0] = cw_t'({3'b0, sq_sb_q[SQ_STEPS-1].wabs});
	assign vy[0] = cw_t'({1'b0, sqr[SQ_STEPS][0][32:0]});
	assign vz[0] = '0;

	always_comb begin
		vec_in.wneg    = sq_sb_q[SQ_STEPS-1].wneg;
		vec_in.x       = sq_sb_q[SQ_STEPS-1].x;
		vec_in.y       = sq_sb_q[SQ_STEPS-1].y;
		vec_in.z       = sq_sb_q[SQ_STEPS-1].z;
		vec_in.len     = sqr[SQ_STEPS][1][31:0];
		vec_in.small_n = sq_sb_q[SQ_STEPS-1].small_n;
	end

	generate
		for (k = 0; k < NS; k++) begin : g_vec
			eta_vec_cell #(.STEP(k)) u_cell (
				.clk(clk), .en(en),
				.x(vx[k]), .y(vy[k]), .z(vz[k]),
				.x_s1(vx[k+1]), .y_s1(vy[k+1]), .z_s1(vz[k+1])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			vec_sb_q[0] <= vec_in;
			for (int i = 1; i < NS; i++) vec_sb_q[i] <= vec_sb_q[i-1];
		end
	end

	// angle rounding and divider setup
	cw_t zc;
	cw_t th;
	cw_t th_rnd;
	cw_t comp [3];
	logic [32:0] mag [3];
	logic [47:0] numer [3];
	logic [2:0] neg;
	div_sb_t sb_s6;
	logic [32:0] rem0_s6 [3];
	logic [QBITS-1:0] nlow_s6 [3];

	always_comb begin
		if (vz[NS] < cw_t'(0)) zc = '0;
		else if (vz[NS] > Q30_HALF_PI) zc = Q30_HALF_PI;
		else zc = vz[NS];
		th = vec_sb_q[NS-1].wneg ? Q30_PI - zc : zc;
		th_rnd = th + cw_t'(32768);
		comp[0] = vec_sb_q[NS-1].x;
		comp[1] = vec_sb_q[NS-1].y;
		comp[2] = vec_sb_q[NS-1].z;
		for (int i = 0; i < 3; i++) begin
			neg[i] = comp[i][CW-1];
			mag[i] = neg[i] ? 33'(-comp[i]) : 33'(comp[i]);
			numer[i] = {1'b0, mag[i], 14'b0} + 48'(vec_sb_q[NS-1].len >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s6.angle   <= th_rnd[31:16];
			sb_s6.len     <= vec_sb_q[NS-1].len;
			sb_s6.neg     <= neg;
			sb_s6.small_n <= vec_sb_q[NS-1].small_n;
			for (int i = 0; i < 3; i++) begin
				rem0_s6[i] <= numer[i][47:15];
				nlow_s6[i] <= numer[i][QBITS-1:0];
			end
		end
	end

	// divider chain, lanes x, y, z
	logic [32:0] dvr [QBITS+1][3];
	logic [QBITS-1:0] dvq [QBITS+1][3];
	logic [QBITS-1:0] dvn [QBITS+1][3];
	div_sb_t div_sb_q [QBITS];

	generate
		for (l = 0; l < 3; l++) begin : g_div_in
			assign dvr[0][l] = rem0_s6[l];
			assign dvq[0][l] = '0;
			assign dvn[0][l] = nlow_s6[l];
		end
		for (k = 0; k < QBITS; k++) begin : g_div
			for (l = 0; l < 3; l++) begin : g_lane
				eta_div_cell u_cell (
					.clk(clk), .en(en),
					.rem(dvr[k][l]), .q(dvq[k][l]), .nlow(dvn[k][l]),
					.len((k == 0) ? sb_s6.len : div_sb_q[(k == 0) ? 0 : k-1].len),
					.rem_s1(dvr[k+1][l]), .q_s1(dvq[k+1][l]), .nlow_s1(dvn[k+1][l])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en) begin
			div_sb_q[0] <= sb_s6;
			for (int i = 1; i < QBITS; i++) div_sb_q[i] <= div_sb_q[i-1];
		end
	end

	// signed axis, permuted as (z, -y, -x); short axis becomes (1,0,0)
	logic signed [15:0] ax [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax[i] = div_sb_q[QBITS-1].neg[i] ? -$signed({1'b0, dvq[QBITS][i]})
				: $signed({1'b0, dvq[QBITS][i]});
		end
		tail.rotation_angle = div_sb_q[QBITS-1].angle;
		if (div_sb_q[QBITS-1].small_n) begin
			tail.axis_first  = '0;
			tail.axis_second = '0;
			tail.axis_third  = -AXIS_ONE;
		end else begin
			tail.axis_first  = ax[2];
			tail.axis_second = -ax[1];
			tail.axis_third  = -ax[0];
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_vld_q && !rotation.ready) begin
			if (push) skid_vld_q <= 1'b1;
		end else if (skid_vld_q) begin
			out_vld_q  <= 1'b1;
			skid_vld_q <= 1'b0;
		end else begin
			out_vld_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (out_vld_q && !rotation.ready) begin
			if (push) skid_q <= tail;
		end else if (skid_vld_q) begin
			res_q <= skid_q;
		end else if (push) begin
			res_q <= tail;
		end
	end

	assign rotation.valid          = out_vld_q;
	assign rotation.axis_first     = res_q.axis_first;
	assign rotation.axis_second    = res_q.axis_second;
	assign rotation.axis_third     = res_q.axis_third;
	assign rotation.rotation_angle = res_q.rotation_angle;
endmodule

### hdl/eta_checker.sv
// port-level checks of the euler to axis-angle block, bound to its top level
// depends on euler_to_axis_angle_assert.svh
`include "euler_to_axis_angle_assert.svh"

module eta_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] rotation_angle
);
	// input backpressure only exists while a result is waiting
	`ETA_ASSERT_SAME(a_full_has_out, clk, arst_n, !in_ready, out_valid, "ready low with no result")
	// the skid stage fills only during an output stall
	`ETA_ASSERT_SAME(a_fill_on_stall, clk, arst_n, $fell(in_ready), $past(out_valid && !out_ready), "ready fell without stall")
	`ETA_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped under stall")
	`ETA_ASSERT_SAME(a_angle_range, clk, arst_n, out_valid && (in_valid || !in_valid), rotation_angle <= 16'd51472, "angle above two pi")
endmodule

bind euler_to_axis_angle eta_port_checker u_eta_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(angles.valid),
	.in_ready(angles.ready),
	.out_valid(rotation.valid),
	.out_ready(rotation.ready),
	.rotation_angle(rotation.rotation_angle)
);

### verif/eta_checker.sv
`timescale 1ns / 100ps
// checker for the euler to axis-angle block: predicts axis and rotation angle per transfer
// depends on eta_pkg, eta_in_if and eta_out_if
module eta_checker import eta_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	eta_in_if     angles,
	eta_out_if    rotation,
	output int    fail_count,
	output int    pending
);

	localparam int STEPS = CORDIC_STEPS > 32 ? 32 : CORDIC_STEPS;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint CORDIC_GAIN = 64'sd652032874;
	localparam longint unsigned NORM_FLOOR = 64'd1152921504606847;

	localparam longint ARCTAN [32] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
		64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
		64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
		64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
		64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
		64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000007,
		64'h00000003, 64'h00000001, 64'h00000000, 64'h00000000
	};

	res_t expected_rotations[$];

	assign pending = expected_rotations.size();

	// q2.30 product, rounded half away from zero
	function automatic longint qmul(input longint a, input longint b);
		longint p;
		longint unsigned m;
		longint r;
		p = a * b;
		m = p < 0 ? longint'(-p) : longint'(p);
		r = longint'((m + (64'd1 << 29)) >> 30);
		return p < 0 ? -r : r;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic void half_sin_cos(input longint h, output longint c, output longint s);
		longint x, y, t;
		bit flip;
		x = CORDIC_GAIN;
		y = 0;
		flip = 0;
		// fold into [-pi/2, pi/2], and if folded negate both results afterwards
		if (h > HALF_PI_Q30) begin
			h -= PI_Q30;
			flip = 1;
		end else if (h < -HALF_PI_Q30) begin
			h += PI_Q30;
			flip = 1;
		end
		for (int i = 0; i < STEPS; i++) begin
			if (h >= 0) begin
				t = x - (y >>> i); y = y + (x >>> i); h -= ARCTAN[i];
			end else begin
				t = x + (y >>> i); y = y - (x >>> i); h += ARCTAN[i];
			end
			x = t;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic longint vector_angle(input longint y, input longint x);
		longint z, t;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			if (y > 0) begin
				t = x + (y >>> i); y = y - (x >>> i); z += ARCTAN[i];
			end else begin
				t = x - (y >>> i); y = y + (x >>> i); z -= ARCTAN[i];
			end
			x = t;
		end
		if (z < 0) z = 0;
		if (z > HALF_PI_Q30) z = HALF_PI_Q30;
		return z;
	endfunction

	function automatic longint axis_unit(input longint c, input longint unsigned len);
		longint unsigned m;
		longint r;
		m = c < 0 ? longint'(-c) : longint'(c);
		r = longint'((m * 16384 + len / 2) / len);
		return c < 0 ? -r : r;
	endfunction

	function automatic res_t predict_rotation(input logic signed [15:0] ax,
		input logic signed [15:0] ay, input logic signed [15:0] az);
		longint c1, s1, c2, s2, c3, s3, c1c2, s1s2, w, x, y, z, ux, uy, uz, theta;
		longint unsigned n, len, sn;
		res_t r;
		half_sin_cos(longint'(ax) * 65536, c1, s1);
		half_sin_cos(-(longint'(az) * 65536), c2, s2);
		half_sin_cos(longint'(ay) * 65536, c3, s3);
		c1c2 = qmul(c1, c2);
		s1s2 = qmul(s1, s2);
		w = qmul(c1c2, c3) - qmul(s1s2, s3);
		x = qmul(c1c2, s3) + qmul(s1s2, c3);
		y = qmul(qmul(s1, c2), c3) - qmul(qmul(c1, s2), s3);
		z = qmul(qmul(c1, s2), c3) - qmul(qmul(s1, c2), s3);
		if (w > ONE_Q30) w = ONE_Q30;
		if (w < -ONE_Q30) w = -ONE_Q30;
		sn = int_sqrt((64'd1 << 60) - longint'(w * w));
		theta = vector_angle(longint'(sn), w < 0 ? -w : w);
		if (w < 0)
			theta = PI_Q30 - theta;
		n = longint'(x * x) + longint'(y * y) + longint'(z * z);
		// short axis falls back to (1,0,0)
		if (n < NORM_FLOOR) begin
			ux = 16384; uy = 0; uz = 0;
		end else begin
			len = int_sqrt(n);
			ux = axis_unit(x, len);
			uy = axis_unit(y, len);
			uz = axis_unit(z, len);
		end
		r.axis_first = 16'(uz);
		r.axis_second = 16'(-uy);
		r.axis_third = 16'(-ux);
		r.rotation_angle = 16'((theta + 32768) >>> 16);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t exp_r;
		if (!arst_n) begin
			fail_count <= 0;
		end else begin
			if (angles.valid && angles.ready)
				expected_rotations.push_back(predict_rotation(angles.angle_x, angles.angle_y,
					angles.angle_z));
			if (rotation.valid && rotation.ready) begin
				if (expected_rotations.size() == 0) begin
					$error("result transfer with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					exp_r = expected_rotations.pop_front();
					if (rotation.axis_first !== exp_r.axis_first ||
						rotation.axis_second !== exp_r.axis_second ||
						rotation.axis_third !== exp_r.axis_third ||
						rotation.rotation_angle !== exp_r.rotation_angle)
						fail_count <= fail_count + 1;
					if (rotation.axis_first !== exp_r.axis_first)
						$error("axis_first expected %0d got %0d", exp_r.axis_first,
							rotation.axis_first);
					if (rotation.axis_second !== exp_r.axis_second)
						$error("axis_second expected %0d got %0d", exp_r.axis_second,
							rotation.axis_second);
					if (rotation.axis_third !== exp_r.axis_third)
						$error("axis_third expected %0d got %0d", exp_r.axis_third,
							rotation.axis_third);
					if (rotation.rotation_angle !== exp_r.rotation_angle)
						$error("rotation_angle expected %0d got %0d", exp_r.rotation_angle,
							rotation.rotation_angle);
				end
			end
		end
	end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// top of the euler to axis-angle testbench: clock, reset, angle stimulus, result stalls, verdict
// depends on eta_pkg, the channel interfaces, eta_checker and the block
module testbench import eta_pkg::*;;

	localparam int LATENCY = 2 * CORDIC_STEPS_DEF + 54;
	localparam int IDLE_LIMIT = 5000;
	localparam int RANDOM_ITEMS = 1800;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_cycles;
	bit   steady;

	eta_in_if  angles_if ();
	eta_out_if rot_if ();

	euler_to_axis_angle dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.angles   (angles_if),
		.rotation (rot_if)
	);

	eta_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.angles     (angles_if),
		.rotation   (rot_if),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
		input logic [15:0] az);
		bit taken;
		int gap;
		angles_if.valid <= 1;
		angles_if.angle_x <= ax;
		angles_if.angle_y <= ay;
		angles_if.angle_z <= az;
		do begin
			@(negedge clk);
			taken = angles_if.ready;
			@(posedge clk);
		end while (!taken);
		gap = pick_gap();
		if (gap > 0) begin
			angles_if.valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [15:0] rand_angle(input bit near_zero);
		if (near_zero) return 16'($signed($urandom_range(0, 400)) - 200);
		return 16'($urandom);
	endfunction

	// result side stalls
	initial begin
		rot_if.ready <= 0;
		@(posedge arst_n);
		forever begin
			rot_if.ready <= 1;
			repeat ($urandom_range(0, 9) < 2 ? $urandom_range(50, 200) : $urandom_range(1, 12))
				@(posedge clk);
			if (!steady) begin
				rot_if.ready <= 0;
				repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 3))
					@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (angles_if.valid && angles_if.ready) || (rot_if.valid && rot_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [15:0] corner [6];
		bit near;
		corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'd25736, 16'd12868, 16'hCDBC};
		steady = 0;
		arst_n = 0;
		angles_if.valid <= 0;
		angles_if.angle_x <= 0;
		angles_if.angle_y <= 0;
		angles_if.angle_z <= 0;
		repeat (4) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// zero rotation gives the short axis; extremes of each field; pi and half pi
		send_angles(0, 0, 0);
		send_angles(16'h0001, 0, 0);
		send_angles(0, 16'hFFFF, 0);
		send_angles(0, 0, 16'h0001);
		for (int i = 0; i < 6; i++)
			send_angles(corner[i], corner[(i + 2) % 6], corner[(i + 4) % 6]);
		send_angles(16'h8000, 16'h8000, 16'h8000);
		send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_angles(16'h8000, 16'h7FFF, 16'h8000);
		send_angles(16'h7FFF, 16'h8000, 16'h7FFF);
		send_angles(16'd25736, 0, 0);
		send_angles(0, 16'd25736, 0);
		send_angles(0, 0, 16'd25736);
		send_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 2) begin
				// hold off until the pipeline has drained
				angles_if.valid <= 0;
				@(posedge clk);
				while (pending != 0) @(posedge clk);
			end
			if (n % 300 == 0) steady = ($urandom_range(0, 2) == 0);
			near = ($urandom_range(0, 9) < 3);
			send_angles(rand_angle(near), rand_angle(near), rand_angle(near));
		end
		angles_if.valid <= 0;

		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
